>>> rtl/core/mme_pkg.sv
// ============================================================================
// mme_pkg
// Shared types, widths and codes for the matrix multiply engine.
// ============================================================================
package mme_pkg;

    // Largest matrix dimension supported by default.
    localparam int MAX_DIM_DEF = 8;

    // Field and datapath widths.
    localparam int SIZE_W    = 4;
    localparam int IDX_F_W   = 3;
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 32;
    localparam int ACC_W     = 36;
    localparam int DOT_W     = 32;
    localparam int MODE_W    = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    // Request kinds carried in tuser.
    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_ROWS_M  = 2'd0;
    localparam logic [1:0] REG_INNER_K = 2'd1;
    localparam logic [1:0] REG_COLS_N  = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // Control flags for one operand pair handed to the multiply-accumulate unit.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_req;

    // A size of zero acts as one and a size above the maximum acts as the maximum.
    function automatic logic [SIZE_W-1:0] f_eff_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] vmax);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > vmax) begin
            r = vmax;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/matrix_multiply_engine.sv
// ============================================================================
// matrix_multiply_engine
// Fixed-point matrix multiply C = A x B with element stores and one shared MAC.
// ============================================================================
// Usage: the slave stream carries requests. tuser selects the kind: load an
// element of A, load an element of B, or compute. Loads write one signed Q8.8
// element at (row, col); loads outside the configured sizes
// are dropped. A compute request streams out every element of C in row-major
// order on the master stream, tlast marking the final one. Each result carries
// its row, column and the Q16.16 dot product, saturated to 32 bits.
// Sizes M, K and N are set through the APB port; the user must do so only
// while no compute is running, as the block does not enforce it. Zero acts
// as one and values above MAX_DIM act as MAX_DIM. Throughput: one
// multiply-accumulate per cycle while operand pairs issue, through a single
// shared unit. Each element of C issues K operand pairs, which then pass
// through the store read, product and accumulate registers; s_axis_tready
// stays low until the last result has been handed to the output register.
// Stalls: the output register holds a result until the receiver takes it; the
// sequencer waits with the finished sum and resumes once the register frees.
// Reset: sizes return to 8, the block goes idle and the output register empties.
// The element stores are not cleared; elements must be written before use.
// ============================================================================
module matrix_multiply_engine #(
    parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata from bit 0: row[2:0], col[5:3], element[21:6], zero pad[23:22]
    input  logic [mme_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // tuser from bit 0: mode[1:0]
    input  logic [mme_pkg::MODE_W-1:0]      s_axis_tuser,
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata from bit 0: out_row[2:0], out_col[5:3], dot_value[37:6], zero pad[39:38]
    output logic [mme_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mme_pkg::APB_AW-1:0]      paddr,
    input  logic [mme_pkg::APB_DW-1:0]      pwdata,
    output logic [mme_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);
    import mme_pkg::*;

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_DIM);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;

    // Configuration registers.
    logic [SIZE_W-1:0] r_rows_m;
    logic [SIZE_W-1:0] r_inner_k;
    logic [SIZE_W-1:0] r_cols_n;
    logic              w_cfg_wr;
    logic [SIZE_W-1:0] w_m;
    logic [SIZE_W-1:0] w_k;
    logic [SIZE_W-1:0] w_n;

    // Request fields.
    logic [IDX_F_W-1:0] w_row;
    logic [IDX_F_W-1:0] w_col;
    logic [ELEM_W-1:0]  w_elem;
    logic [MODE_W-1:0]  w_mode;
    logic               w_in_acc;

    // Store ports.
    logic              w_wen_a;
    logic              w_wen_b;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr_a;
    logic [ADDR_W-1:0] w_raddr_b;
    logic [ELEM_W-1:0] w_rdata_a;
    logic [ELEM_W-1:0] w_rdata_b;

    // Sequencer.
    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] n_i;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] n_j;
    logic [IDX_W-1:0] r_t;
    logic [IDX_W-1:0] n_t;
    logic             w_t_last;
    logic             w_j_last;
    logic             w_i_last;
    t_mac_req         n_req;
    t_mac_req         r_rd_req;
    logic             w_done;
    logic             w_take;
    logic             w_out_free;
    logic [DOT_W-1:0] w_sum;

    // Output register.
    logic               r_ovalid;
    logic [IDX_F_W-1:0] r_orow;
    logic [IDX_F_W-1:0] r_ocol;
    logic [DOT_W-1:0]   r_odot;
    logic               r_olast;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; reads return
    // the stored size, and unmapped addresses read as zero.
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_m  <= SIZE_RESET;
            r_inner_k <= SIZE_RESET;
            r_cols_n  <= SIZE_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_ROWS_M:  r_rows_m  <= pwdata[SIZE_W-1:0];
                REG_INNER_K: r_inner_k <= pwdata[SIZE_W-1:0];
                REG_COLS_N:  r_cols_n  <= pwdata[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ROWS_M:  prdata = APB_DW'(r_rows_m);
            REG_INNER_K: prdata = APB_DW'(r_inner_k);
            REG_COLS_N:  prdata = APB_DW'(r_cols_n);
            default:     prdata = '0;
        endcase
    end

    assign w_m = f_eff_size(r_rows_m, MAX_SIZE);
    assign w_k = f_eff_size(r_inner_k, MAX_SIZE);
    assign w_n = f_eff_size(r_cols_n, MAX_SIZE);

    // ------------------------------------------------------------------
    // Element loads. Both stores are addressed row*MAX_DIM+col; the bounds
    // check keeps every accepted address inside the store.
    // ------------------------------------------------------------------
    assign w_row    = s_axis_tdata[2:0];
    assign w_col    = s_axis_tdata[5:3];
    assign w_elem   = s_axis_tdata[21:6];
    assign w_mode   = s_axis_tuser;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    assign w_wen_a = w_in_acc && (w_mode == MODE_LOAD_A) &&
                     (SIZE_W'(w_row) < w_m) && (SIZE_W'(w_col) < w_k);
    assign w_wen_b = w_in_acc && (w_mode == MODE_LOAD_B) &&
                     (SIZE_W'(w_row) < w_k) && (SIZE_W'(w_col) < w_n);
    assign w_waddr = ADDR_W'(int'(w_row) * MAX_DIM + int'(w_col));

    // During a dot product, A is walked along row i and B down column j.
    assign w_raddr_a = ADDR_W'(int'(r_i) * MAX_DIM + int'(r_t));
    assign w_raddr_b = ADDR_W'(int'(r_t) * MAX_DIM + int'(r_j));

    mme_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (ELEM_W)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_wen   (w_wen_a),
        .i_waddr (w_waddr),
        .i_wdata (w_elem),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rdata_a)
    );

    mme_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (ELEM_W)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_wen   (w_wen_b),
        .i_waddr (w_waddr),
        .i_wdata (w_elem),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rdata_b)
    );

    // ------------------------------------------------------------------
    // Sequencer. In ISSUE one operand pair is read per cycle; in WAIT the
    // finished sum moves to the output register once that register is free,
    // then the next element of C starts or the block returns to idle.
    // ------------------------------------------------------------------
    assign s_axis_tready = (r_state == S_IDLE);

    assign w_t_last = (SIZE_W'(r_t) + SIZE_W'(1)) == w_k;
    assign w_j_last = (SIZE_W'(r_j) + SIZE_W'(1)) == w_n;
    assign w_i_last = (SIZE_W'(r_i) + SIZE_W'(1)) == w_m;

    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_take     = (r_state == S_WAIT) && w_done && w_out_free;

    always_comb begin
        n_req.valid = (r_state == S_ISSUE);
        n_req.first = (r_t == '0);
        n_req.last  = w_t_last;
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_t     = r_t;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (w_mode == MODE_COMPUTE)) begin
                    n_state = S_ISSUE;
                    n_i     = '0;
                    n_j     = '0;
                    n_t     = '0;
                end
            end
            S_ISSUE: begin
                if (w_t_last) begin
                    n_state = S_WAIT;
                    n_t     = '0;
                end else begin
                    n_t = r_t + IDX_W'(1);
                end
            end
            S_WAIT: begin
                if (w_take) begin
                    if (w_j_last) begin
                        n_j = '0;
                        if (w_i_last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_i     = r_i + IDX_W'(1);
                            n_state = S_ISSUE;
                        end
                    end else begin
                        n_j     = r_j + IDX_W'(1);
                        n_state = S_ISSUE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_i      <= '0;
            r_j      <= '0;
            r_t      <= '0;
            r_rd_req <= '0;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_j      <= n_j;
            r_t      <= n_t;
            r_rd_req <= n_req;
        end
    end

    // The request flags pass through a register to line up with the registered store data.
    mme_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_rd_req),
        .i_a     (w_rdata_a),
        .i_b     (w_rdata_b),
        .i_take  (w_take),
        .o_done  (w_done),
        .o_sum   (w_sum)
    );

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_take) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_orow  <= IDX_F_W'(r_i);
            r_ocol  <= IDX_F_W'(r_j);
            r_odot  <= w_sum;
            r_olast <= w_i_last && w_j_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_odot, r_ocol, r_orow};
    assign m_axis_tlast  = r_olast;

endmodule

>>> rtl/core/mme_ram.sv
// ============================================================================
// mme_ram
// Matrix element store: one write port and one read port with registered data.
// ============================================================================
module mme_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_wen,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/mme_mac.sv
// ============================================================================
// mme_mac
// Shared multiply-accumulate unit with a product register and 32-bit saturation.
// ============================================================================
module mme_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mme_pkg::t_mac_req                  i_req,
    input  logic signed [mme_pkg::ELEM_W-1:0]  i_a,
    input  logic signed [mme_pkg::ELEM_W-1:0]  i_b,
    input  logic                               i_take,
    output logic                               o_done,
    output logic signed [mme_pkg::DOT_W-1:0]   o_sum
);
    import mme_pkg::*;

    logic                     r_pv;
    logic                     r_pfirst;
    logic                     r_plast;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_base;
    logic                     r_done;
    logic [ACC_W-DOT_W:0]     w_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_pv   <= i_req.valid;
            r_done <= (r_pv && r_plast) || (r_done && !i_take);
        end
    end

    assign w_base = r_pfirst ? '0 : r_acc;

    always_ff @(posedge i_clk) begin
        r_pfirst <= i_req.first;
        r_plast  <= i_req.last;
        r_prod   <= PROD_W'(i_a) * PROD_W'(i_b);
        if (r_pv) begin
            r_acc <= w_base + ACC_W'(r_prod);
        end
    end

    // The sum fits when all bits above the result's sign bit match it.
    assign w_top = r_acc[ACC_W-1:DOT_W-1];

    always_comb begin
        if ((w_top == '0) || (w_top == '1)) begin
            o_sum = r_acc[DOT_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            o_sum = {1'b1, {(DOT_W-1){1'b0}}};
        end else begin
            o_sum = {1'b0, {(DOT_W-1){1'b1}}};
        end
    end

    assign o_done = r_done;

endmodule

>>> rtl/core/mme_chk.sv
// ============================================================================
// mme_chk
// Port-level checks for the matrix multiply engine, bound to the top level.
// ============================================================================
module mme_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [mme_pkg::MODE_W-1:0]    s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [mme_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tlast
);
    import mme_pkg::*;

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // A compute request makes the block busy in the next cycle.
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_COMPUTE) |=>
            !s_axis_tready)
        else $error("block still ready after a compute request");

    // Loads and unused kinds leave the block ready in the next cycle.
    a_load_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != MODE_COMPUTE) |=>
            s_axis_tready)
        else $error("load request held the block");

    // An idle block with an empty output register keeps that register empty.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result without a compute in progress");

    // Reset leaves the block idle with an empty output register.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready && !m_axis_tvalid)
        else $error("block not idle after reset");

endmodule

bind matrix_multiply_engine mme_chk u_mme_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
